@@ rtl/core/bmpg_pkg.sv @@
// shared types and constants for the boxcar motion profile generator
package bmpg_pkg;

  localparam int unsigned MaxFirstLen  = 256;
  localparam int unsigned MaxSecondLen = 256;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned Ptr1W        = $clog2(MaxFirstLen);
  localparam int unsigned Ptr2W        = $clog2(MaxSecondLen);
  localparam int unsigned Fill1W       = $clog2(MaxFirstLen + 1);
  localparam int unsigned Fill2W       = $clog2(MaxSecondLen + 1);
  localparam int unsigned MeanW        = FracBits + 1;
  localparam int unsigned Sum2W        = MeanW + Fill2W;
  localparam int unsigned DivW         = 64;
  localparam int unsigned DivCntW      = $clog2(DivW + 1);

  // register addresses (byte address / 4)
  localparam logic [2:0] RegDistance = 3'd0;
  localparam logic [2:0] RegMaxVel   = 3'd1;
  localparam logic [2:0] RegAccel    = 3'd2;
  localparam logic [2:0] RegJerk     = 3'd3;
  localparam logic [2:0] RegPeriod   = 3'd4;

  typedef enum logic [3:0] {
    StIdle, StLen1, StLen2, StSteps, StFilt1, StMean, StFilt2,
    StVel, StAcc, StDist, StDquo, StDacc, StOut
  } state_e;

  // division operand selects
  typedef enum logic [2:0] {
    DivLen1, DivLen2, DivSteps, DivMean, DivVel, DivAcc
  } div_sel_e;

  typedef struct packed {
    logic     clear;
    logic     div_start;
    div_sel_e div_sel;
    logic     ld_len1;
    logic     ld_len2;
    logic     ld_steps;
    logic     filt1;
    logic     ld_mean;
    logic     filt2;
    logic     ld_vel;
    logic     ld_acc;
    logic     ld_dprod;
    logic     ld_dquo;
    logic     ld_dist;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

@@ rtl/core/bmpg_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
module bmpg_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bmpg_pkg::DivW-1:0] num_i,
  input  logic [bmpg_pkg::DivW-1:0] den_i,
  output logic [bmpg_pkg::DivW-1:0] quo_o,
  output logic                     done_o
);
  import bmpg_pkg::*;

  logic [DivW-1:0]    quo_q, quo_d, den_q, den_d;
  logic [DivW:0]      rem_q, rem_d, trial;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;

  // shift-subtract step
  always_comb begin
    trial  = {rem_q[DivW-1:0], quo_q[DivW-1]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = DivCntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;
endmodule

@@ rtl/core/bmpg_ctrl.sv @@
// sequencer for one profile tick
module bmpg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              in_restart_i,
  input  logic              out_free_i,
  input  bmpg_pkg::status_t status_i,
  output bmpg_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              out_load_o
);
  import bmpg_pkg::*;

  state_e state_q, state_d;
  logic   started_q, started_d;

  // next state
  always_comb begin
    state_d   = state_q;
    started_d = 1'b0;
    unique case (state_q)
      StIdle:  if (in_fire_i) state_d = StLen1;
      StLen1:  if (status_i.div_done) state_d = StLen2;
      StLen2:  if (status_i.div_done) state_d = StSteps;
      StSteps: if (status_i.div_done) state_d = StFilt1;
      StFilt1: state_d = StMean;
      StMean:  if (status_i.div_done) state_d = StFilt2;
      StFilt2: state_d = StVel;
      StVel:   if (status_i.div_done) state_d = StAcc;
      StAcc:   if (status_i.div_done) state_d = StDist;
      StDist:  state_d = StDquo;
      StDquo:  state_d = StDacc;
      StDacc:  state_d = StOut;
      StOut:   if (out_free_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (state_d != state_q) started_d = 1'b0;
    else started_d = 1'b1;
  end

  // command decode
  always_comb begin
    cmd_o = '0;
    cmd_o.clear = (state_q == StIdle) && in_fire_i && in_restart_i;
    unique case (state_q)
      StLen1:  begin cmd_o.div_sel = DivLen1;  cmd_o.ld_len1 = status_i.div_done; end
      StLen2:  begin cmd_o.div_sel = DivLen2;  cmd_o.ld_len2 = status_i.div_done; end
      StSteps: begin cmd_o.div_sel = DivSteps; cmd_o.ld_steps = status_i.div_done; end
      StFilt1: cmd_o.filt1 = 1'b1;
      StMean:  begin cmd_o.div_sel = DivMean;  cmd_o.ld_mean = status_i.div_done; end
      StFilt2: cmd_o.filt2 = 1'b1;
      StVel:   begin cmd_o.div_sel = DivVel;   cmd_o.ld_vel = status_i.div_done; end
      StAcc:   begin cmd_o.div_sel = DivAcc;   cmd_o.ld_acc = status_i.div_done; end
      StDist:  cmd_o.ld_dprod = 1'b1;
      StDquo:  cmd_o.ld_dquo = 1'b1;
      StDacc:  cmd_o.ld_dist = 1'b1;
      default: cmd_o.div_sel = DivLen1;
    endcase
    cmd_o.div_start = !started_q && (state_q == StLen1 || state_q == StLen2 ||
                      state_q == StSteps || state_q == StMean || state_q == StVel ||
                      state_q == StAcc);
  end

  assign busy_o     = (state_q != StIdle);
  assign out_load_o = (state_q == StOut) && out_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
    end
  end
endmodule

@@ rtl/core/bmpg_dp.sv @@
// profile datapath: filters, shared divider operands and accumulators
module bmpg_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmpg_pkg::cmd_t      cmd_i,
  output bmpg_pkg::status_t   status_o,
  input  logic [23:0]         distance_ticks_i,
  input  logic [15:0]         max_velocity_i,
  input  logic [15:0]         accel_time_ms_i,
  input  logic [15:0]         jerk_time_ms_i,
  input  logic [9:0]          period_ms_i,
  output logic [23:0]         velocity_cmd_o,
  output logic signed [31:0]  acceleration_o,
  output logic [31:0]         elapsed_distance_o,
  output logic [31:0]         elapsed_time_ms_o,
  output logic                on_target_o
);
  import bmpg_pkg::*;

  logic [9:0]  per;
  logic [15:0] mv;
  logic [DivW-1:0] div_num, div_den, quo;
  logic            div_done;

  logic [Fill1W-1:0] len1_q;
  logic [Fill2W-1:0] len2_q;
  logic [40:0]       steps_q;
  logic [31:0]       step_q;
  logic              win1 [MaxFirstLen];
  logic              old1_q;
  logic [Fill1W-1:0] sum1_q, fill1_q;
  logic [Ptr1W-1:0]  ptr1_q;
  logic [MeanW-1:0]  win2 [MaxSecondLen];
  logic [MeanW-1:0]  old2_q;
  logic [Sum2W-1:0]  sum2_q;
  logic [Fill2W-1:0] fill2_q;
  logic [Ptr2W-1:0]  ptr2_q, old2_idx;
  logic [MeanW-1:0]  mean_q;
  logic [23:0]       vel_q, prev_q;
  logic signed [31:0] acc_q;
  logic [31:0]       dist_q, time_q;
  logic              ontgt_q;
  logic              input_bit;
  logic [Ptr1W-1:0]  old1_idx;
  logic [FracBits+Fill1W+Fill2W+2:0] num_v;
  logic [FracBits+Fill2W+1:0]        den_v;
  logic signed [25:0] dv;
  logic [24:0]       dv_mag;
  logic [32:0]       dsum, tsum;
  logic [63:0]       vel_raw;
  logic [FracBits+Fill1W-1:0] mean_raw;
  logic [34:0]       dprod_full;
  logic [31:0]       dprod_q;
  logic [62:0]       drecip;
  logic [27:0]       dquo_q;

  assign per = (period_ms_i == '0) ? 10'd1 : period_ms_i;
  assign mv  = (max_velocity_i == '0) ? 16'd1 : max_velocity_i;

  assign input_bit = ({9'd0, step_q} < steps_q);
  assign old1_idx  = ptr1_q - fill1_q[Ptr1W-1:0];
  assign old2_idx  = ptr2_q - fill2_q[Ptr2W-1:0];
  assign num_v = {(Fill2W+2)'(0), sum1_q, FracBits'(0)} + (FracBits+Fill1W+Fill2W+3)'(mean_q)
               + (FracBits+Fill1W+Fill2W+3)'(sum2_q);
  assign den_v = {(Fill2W+2)'(0) + (Fill2W+2)'(len1_q) + (Fill2W+2)'(len2_q) + 1'b1,
                  FracBits'(0)};
  assign dv     = $signed({2'b0, vel_q}) - $signed({2'b0, prev_q});
  assign dv_mag = dv[25] ? 25'(-dv) : dv[24:0];

  // divider operand select; product terms are narrow enough for one multiplier each
  always_comb begin
    unique case (cmd_i.div_sel)
      DivLen1:  begin div_num = DivW'(accel_time_ms_i) + DivW'(per) - 1'b1;
                      div_den = DivW'(per); end
      DivLen2:  begin div_num = DivW'(jerk_time_ms_i) + DivW'(per) - 1'b1;
                      div_den = DivW'(per); end
      DivSteps: begin div_num = DivW'(distance_ticks_i) * 64'd100 + DivW'(mv) * DivW'(per)
                                - 1'b1;
                      div_den = DivW'(mv) * DivW'(per); end
      DivMean:  begin div_num = DivW'({sum1_q, FracBits'(0)}); div_den = DivW'(len1_q); end
      DivVel:   begin div_num = DivW'(num_v) * DivW'(mv) * 64'd256; div_den = DivW'(den_v); end
      DivAcc:   begin div_num = DivW'({dv_mag, 8'd0}); div_den = DivW'(per) * 64'd100; end
      default:  begin div_num = '0; div_den = 64'd1; end
    endcase
  end

  bmpg_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(div_num), .den_i(div_den),
    .quo_o(quo), .done_o(div_done)
  );
  assign status_o.div_done = div_done;

  assign mean_raw = quo[FracBits+Fill1W-1:0];
  assign vel_raw  = quo;

  // distance step x/200 as (x>>3)/25; 0x51EB851F = ceil(2^35/25), exact for 32-bit x
  assign dprod_full = (35'(prev_q) + 35'(vel_q)) * 35'(per);
  assign drecip     = 63'(dprod_q) * 63'(32'h51EB_851F);
  assign dsum = {1'b0, dist_q} + 33'(dquo_q);
  assign tsum = {1'b0, time_q} + 33'(per);

  // window storage, oldest entries read ahead of each filter update
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_steps) old1_q <= win1[old1_idx];
    if (cmd_i.filt1) win1[ptr1_q] <= input_bit;
    if (cmd_i.ld_mean) old2_q <= win2[old2_idx];
    if (cmd_i.filt2) win2[ptr2_q] <= mean_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len1_q <= '0; len2_q <= '0; steps_q <= '0; step_q <= '0;
      sum1_q <= '0; fill1_q <= '0; ptr1_q <= '0; sum2_q <= '0; fill2_q <= '0;
      ptr2_q <= '0; mean_q <= '0; vel_q <= '0; prev_q <= '0; acc_q <= '0;
      dist_q <= '0; time_q <= '0; ontgt_q <= 1'b0; dprod_q <= '0; dquo_q <= '0;
    end else if (cmd_i.clear) begin
      step_q <= '0; sum1_q <= '0; fill1_q <= '0; ptr1_q <= '0;
      sum2_q <= '0; fill2_q <= '0; ptr2_q <= '0; prev_q <= '0; dist_q <= '0;
      time_q <= '0;
    end else begin
      // filter lengths clamped to 1..max
      if (cmd_i.ld_len1)
        len1_q <= (quo == 0) ? Fill1W'(1) :
                  (quo > MaxFirstLen) ? Fill1W'(MaxFirstLen) : quo[Fill1W-1:0];
      if (cmd_i.ld_len2)
        len2_q <= (quo == 0) ? Fill2W'(1) :
                  (quo > MaxSecondLen) ? Fill2W'(MaxSecondLen) : quo[Fill2W-1:0];
      if (cmd_i.ld_steps) steps_q <= quo[40:0];
      // first filter update
      if (cmd_i.filt1) begin
        if (step_q != 32'hFFFF_FFFF) step_q <= step_q + 1'b1;
        ptr1_q <= ptr1_q + 1'b1;
        if (fill1_q + 1'b1 > len1_q)
          sum1_q <= sum1_q - Fill1W'(old1_q) + Fill1W'(input_bit);
        else begin
          fill1_q <= fill1_q + 1'b1;
          sum1_q  <= sum1_q + Fill1W'(input_bit);
        end
      end
      if (cmd_i.ld_mean)
        mean_q <= (mean_raw > (FracBits+Fill1W)'(1 << FracBits)) ?
                  MeanW'(1 << FracBits) : mean_raw[MeanW-1:0];
      // second filter update
      if (cmd_i.filt2) begin
        ptr2_q <= ptr2_q + 1'b1;
        if (fill2_q + 1'b1 > len2_q)
          sum2_q <= sum2_q - Sum2W'(old2_q) + Sum2W'(mean_q);
        else begin
          fill2_q <= fill2_q + 1'b1;
          sum2_q  <= sum2_q + Sum2W'(mean_q);
        end
      end
      if (cmd_i.ld_vel)
        vel_q <= (vel_raw > 64'hFF_FFFF) ? 24'hFF_FFFF : vel_raw[23:0];
      if (cmd_i.ld_acc) acc_q <= dv[25] ? -$signed(quo[31:0]) : $signed(quo[31:0]);
      // trapezoid distance step: product registered in dprod_q, then quotient in dquo_q
      if (cmd_i.ld_dprod) dprod_q <= dprod_full[34:3];
      if (cmd_i.ld_dquo) dquo_q <= drecip[62:35];
      // accumulators and on-target
      if (cmd_i.ld_dist) begin
        dist_q  <= dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
        time_q  <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
        prev_q  <= vel_q;
        ontgt_q <= ({9'd0, step_q} >= steps_q + 41'(len1_q) + 41'(len2_q));
      end
    end
  end

  assign velocity_cmd_o     = vel_q;
  assign acceleration_o     = acc_q;
  assign elapsed_distance_o = dist_q;
  assign elapsed_time_ms_o  = time_q;
  assign on_target_o        = ontgt_q;
endmodule

@@ rtl/core/boxcar_motion_profile_generator_top.sv @@
// Two-stage boxcar motion profile generator, top level.
// Usage:
//  - program the five registers over the APB port while idle
//  - each transfer on the slave stream (tdata[0] = restart) advances one tick
//  - one result transfer per tick leaves on the master stream
// From the accepted input transfer until the result is offered, a tick runs
// the shared bit-serial divider six times (start, 64 quotient bits, done)
// plus six other steps. One tick is processed at a time; s_axis_tready is
// low while a tick runs, so no new tick is taken until the last one is done.
// The result register holds its value while the receiver stalls; the next
// tick is accepted as soon as the sequencer finishes, and its result waits
// for the output register to free up.
// Reset clears all profile state and loads the register defaults
// (max velocity 1, period 10 ms); restart clears the profile before its tick.
module boxcar_motion_profile_generator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [0] restart
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // velocity_cmd, acceleration, elapsed_distance, elapsed_time_ms
                                       // [23:0] [55:24] [87:56] [119:88], [120] on_target
);
  import bmpg_pkg::*;

  logic [23:0] dist_q;
  logic [15:0] mv_q, acc_t_q, jerk_q;
  logic [9:0]  per_q;
  cmd_t        cmd;
  status_t     status;
  logic        busy, out_load, out_free, in_fire;
  logic [23:0] vel;
  logic signed [31:0] acc;
  logic [31:0] edist, etime;
  logic        ontgt;
  logic        ovalid_q;
  logic [120:0] odata_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0; mv_q <= 16'd1; acc_t_q <= '0; jerk_q <= '0; per_q <= 10'd10;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        RegDistance: dist_q  <= pwdata[23:0];
        RegMaxVel:   mv_q    <= pwdata[15:0];
        RegAccel:    acc_t_q <= pwdata[15:0];
        RegJerk:     jerk_q  <= pwdata[15:0];
        RegPeriod:   per_q   <= pwdata[9:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegDistance: prdata = {8'd0, dist_q};
      RegMaxVel:   prdata = {16'd0, mv_q};
      RegAccel:    prdata = {16'd0, acc_t_q};
      RegJerk:     prdata = {16'd0, jerk_q};
      RegPeriod:   prdata = {22'd0, per_q};
      default:     prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ovalid_q || m_axis_tready;

  bmpg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .in_restart_i(s_axis_tdata[0]),
    .out_free_i(out_free), .status_i(status), .cmd_o(cmd), .busy_o(busy),
    .out_load_o(out_load)
  );

  bmpg_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .distance_ticks_i(dist_q), .max_velocity_i(mv_q), .accel_time_ms_i(acc_t_q),
    .jerk_time_ms_i(jerk_q), .period_ms_i(per_q),
    .velocity_cmd_o(vel), .acceleration_o(acc), .elapsed_distance_o(edist),
    .elapsed_time_ms_o(etime), .on_target_o(ontgt)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (out_load) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (out_load) odata_q <= {ontgt, etime, edist, acc, vel};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, odata_q};
endmodule

@@ rtl/core/bmpg_checker.sv @@
// port-level checks for the motion profile generator
module bmpg_props (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // no new tick is taken in the cycle after one was accepted
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second tick accepted during processing");
  // padding bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[127:121] == 7'd0)
    else $error("padding bits set");
endmodule

bind boxcar_motion_profile_generator_top bmpg_props u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);

@@ tb/bmpg_checker.sv @@
// profile predictor and result checker for the boxcar motion profile generator
module bmpg_checker
  import bmpg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [0] restart
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,   // [23:0] velocity, [55:24] accel, [87:56] distance,
                                       // [119:88] time, [120] on_target
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0] velocity;
    logic [31:0] accel;
    logic [31:0] distance;
    logic [31:0] elapsed;
    logic        on_target;
  } tick_result_t;

  // programmed registers as the block should see them
  logic [23:0] distance_reg;
  logic [15:0] max_vel_reg;
  logic [15:0] accel_time_reg;
  logic [15:0] jerk_time_reg;
  logic [9:0]  period_reg;

  // profile state
  longint      step_cnt;
  logic        accel_win [MaxFirstLen];
  longint      accel_sum, accel_fill, accel_ptr;
  longint      jerk_win [MaxSecondLen];
  longint      jerk_sum, jerk_fill, jerk_ptr;
  longint      prev_vel, dist_total, time_total;

  tick_result_t expected_results[$];

  function automatic void clear_profile();
    step_cnt = 0;
    foreach (accel_win[i]) accel_win[i] = 1'b0;
    foreach (jerk_win[i]) jerk_win[i] = 0;
    accel_sum = 0; accel_fill = 0; accel_ptr = 0;
    jerk_sum = 0; jerk_fill = 0; jerk_ptr = 0;
    prev_vel = 0; dist_total = 0; time_total = 0;
  endfunction

  function automatic longint ceil_div(longint a, longint b);
    return (a + b - 1) / b;
  endfunction

  function automatic longint clamp_len(longint v, longint hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // one tick of the profile, returns the result it should produce
  function automatic tick_result_t advance_profile(logic restart);
    tick_result_t r;
    longint per, mv, len1, len2, steps, feed, oldest, mean, num, vel, dv, acc, sum;
    if (restart) clear_profile();
    per   = (period_reg == 0) ? 1 : period_reg;
    mv    = (max_vel_reg == 0) ? 1 : max_vel_reg;
    len1  = clamp_len(ceil_div(accel_time_reg, per), MaxFirstLen);
    len2  = clamp_len(ceil_div(jerk_time_reg, per), MaxSecondLen);
    steps = ceil_div(longint'(distance_reg) * 100, mv * per);
    feed  = (step_cnt < steps) ? 1 : 0;
    if (step_cnt != 64'hFFFF_FFFF) step_cnt++;

    // first filter
    oldest = (accel_ptr + MaxFirstLen - accel_fill) % MaxFirstLen;
    if (accel_fill + 1 > len1) accel_sum -= accel_win[oldest];
    else accel_fill++;
    accel_win[accel_ptr] = feed[0];
    accel_sum += feed;
    accel_ptr = (accel_ptr + 1) % MaxFirstLen;

    // mean saturates at one when the window outgrew a shortened length
    mean = (accel_sum << FracBits) / len1;
    if (mean > (longint'(1) << FracBits)) mean = longint'(1) << FracBits;

    // second filter
    oldest = (jerk_ptr + MaxSecondLen - jerk_fill) % MaxSecondLen;
    if (jerk_fill + 1 > len2) jerk_sum -= jerk_win[oldest];
    else jerk_fill++;
    jerk_win[jerk_ptr] = mean;
    jerk_sum += mean;
    jerk_ptr = (jerk_ptr + 1) % MaxSecondLen;

    num = (accel_sum << FracBits) + mean + jerk_sum;
    vel = (num * mv * 256) / ((len1 + len2 + 1) << FracBits);
    if (vel > 64'hFF_FFFF) vel = 64'hFF_FFFF;
    dv  = vel - prev_vel;
    acc = (dv * 256) / (100 * per);

    sum = dist_total + ((prev_vel + vel) * per) / 200;
    dist_total = (sum > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sum;
    sum = time_total + per;
    time_total = (sum > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sum;
    prev_vel = vel;

    r.velocity  = vel[23:0];
    r.accel     = acc[31:0];
    r.distance  = dist_total[31:0];
    r.elapsed   = time_total[31:0];
    r.on_target = (step_cnt >= steps + len1 + len2);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want, got;
    if (!rst_ni) begin
      distance_reg   = '0;
      max_vel_reg    = 16'd1;
      accel_time_reg = '0;
      jerk_time_reg  = '0;
      period_reg     = 10'd10;
      clear_profile();
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegDistance: distance_reg   = pwdata[23:0];
          RegMaxVel:   max_vel_reg    = pwdata[15:0];
          RegAccel:    accel_time_reg = pwdata[15:0];
          RegJerk:     jerk_time_reg  = pwdata[15:0];
          RegPeriod:   period_reg     = pwdata[9:0];
          default: ;
        endcase
      end
      // accepted tick
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(advance_profile(s_axis_tdata[0]));
      // result transfer
      if (m_axis_tvalid && m_axis_tready) begin
        got.velocity  = m_axis_tdata[23:0];
        got.accel     = m_axis_tdata[55:24];
        got.distance  = m_axis_tdata[87:56];
        got.elapsed   = m_axis_tdata[119:88];
        got.on_target = m_axis_tdata[120];
        if (expected_results.size() == 0) begin
          $error("result transfer with no tick outstanding");
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.velocity != want.velocity) begin
            $error("velocity_cmd: expected %0h got %0h", want.velocity, got.velocity);
            fail_count_o++;
          end
          if (got.accel != want.accel) begin
            $error("acceleration: expected %0h got %0h", want.accel, got.accel);
            fail_count_o++;
          end
          if (got.distance != want.distance) begin
            $error("elapsed_distance: expected %0h got %0h", want.distance, got.distance);
            fail_count_o++;
          end
          if (got.elapsed != want.elapsed) begin
            $error("elapsed_time_ms: expected %0h got %0h", want.elapsed, got.elapsed);
            fail_count_o++;
          end
          if (got.on_target != want.on_target) begin
            $error("on_target: expected %0b got %0b", want.on_target, got.on_target);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

@@ tb/tb_top.sv @@
// stimulus and verdict for the boxcar motion profile generator
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bmpg_pkg::*;

  localparam int TickLatency = 600;
  localparam longint CycleLimit = 4_000_000;
  localparam int TargetTicks = 1350;

  logic         clk_i, rst_ni;
  logic         psel, penable, pwrite, pready;
  logic [4:0]   paddr;
  logic [31:0]  pwdata, prdata;
  logic         s_axis_tvalid, s_axis_tready;
  logic [7:0]   s_axis_tdata;   // [0] restart
  logic         m_axis_tvalid, m_axis_tready;
  logic [127:0] m_axis_tdata;   // [23:0] velocity, [55:24] accel, [87:56] distance,
                                // [119:88] time, [120] on_target
  int           fail_count, pending;
  int           send_idle_pct, recv_idle_pct;
  bit           hold_go;
  longint       cycles;
  int           ticks_sent;

  boxcar_motion_profile_generator_top uut (.*);

  bmpg_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic bus_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_profile(int dist_ticks, int mv, int acc_t, int jerk_t, int per);
    reg_write(RegDistance, dist_ticks);
    reg_write(RegMaxVel, mv);
    reg_write(RegAccel, acc_t);
    reg_write(RegJerk, jerk_t);
    reg_write(RegPeriod, per);
    bus_release();
    @(posedge clk_i);
  endtask

  // valid stays high between back-to-back ticks
  task automatic send_tick(bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
  endtask

  // stop offering and wait for every result, then for the block to go quiet
  task automatic drain();
    longint start;
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    start = cycles;
    while (pending != 0) begin
      @(posedge clk_i);
      if (cycles - start > 200_000) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
    repeat (TickLatency) @(posedge clk_i);
  endtask

  function automatic int pick_len_time(int per);
    if ($urandom_range(9) == 0) return 65535;
    if ($urandom_range(9) == 0) return 0;
    return (per * 40 > 65535) ? $urandom_range(65535) : $urandom_range(per * 40);
  endfunction

  initial begin
    int per, mv, eff_per, eff_mv, dist_val, n;
    longint span;
    bit hold_used;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    hold_go = 1'b0; ticks_sent = 0; hold_used = 1'b0;
    send_idle_pct = 10; recv_idle_pct = 60;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults, restart in the middle
    send_tick(1'b0); send_tick(1'b1); send_tick(1'b0);
    drain();
    // ordinary trapezoid
    program_profile(1000, 100, 50, 30, 10);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    drain();
    // widest fields, zero times, saturating distance
    program_profile(24'hFF_FFFF, 16'hFFFF, 0, 0, 10'h3FF);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    drain();
    // zero period and velocity, clamped lengths; write past the register list
    program_profile(0, 0, 16'hFFFF, 16'hFFFF, 0);
    reg_write(3'd5, 32'hFFFF_FFFF);
    reg_write(3'd7, 32'h0);
    bus_release();
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();

    // fill a long first window, then shorten both lengths without restart
    program_profile(24'hFF_FFFF, 16'hFFFF, 255, 255, 1);
    send_tick(1'b1);
    repeat (299) send_tick(1'b0);
    drain();
    program_profile(24'hFF_FFFF, 16'hFFFF, 1, 0, 1);
    repeat (20) send_tick(1'b0);
    drain();

    // random profiles
    while (ticks_sent < TargetTicks) begin
      if (ticks_sent < 650) begin
        send_idle_pct = 10; recv_idle_pct = 60;
      end else if (ticks_sent < 1000) begin
        send_idle_pct = 60; recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0: per = 0;
        1: per = 1023;
        2: per = 1;
        default: per = $urandom_range(1, 1000);
      endcase
      case ($urandom_range(9))
        0: mv = 0;
        1: mv = 65535;
        default: mv = $urandom_range(1, 65535);
      endcase
      eff_per = (per == 0) ? 1 : per;
      eff_mv  = (mv == 0) ? 1 : mv;
      span = longint'(eff_mv) * eff_per * 60 / 100;
      if (span > 24'hFF_FFFF) span = 24'hFF_FFFF;
      dist_val = ($urandom_range(19) == 0) ? 24'hFF_FFFF : $urandom_range(int'(span));
      program_profile(dist_val, mv, pick_len_time(eff_per), pick_len_time(eff_per), per);
      // first long receiver hold-off keeps the sender offering
      if (ticks_sent >= 500 && !hold_used) begin
        hold_go = 1'b1;
        hold_used = 1'b1;
      end
      n = $urandom_range(10, 120);
      send_tick($urandom_range(4) != 0);
      repeat (n - 1) send_tick($urandom_range(49) == 0);
      drain();
    end

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bmpg_pkg.sv
rtl/core/bmpg_div.sv
rtl/core/bmpg_ctrl.sv
rtl/core/bmpg_dp.sv
rtl/core/boxcar_motion_profile_generator_top.sv
rtl/core/bmpg_checker.sv
tb/bmpg_checker.sv
tb/tb_top.sv
